// ----- src/gnms_pkg.sv -----
// Shared types, constants and helpers for the gradient non-maximum suppression block.
`default_nettype none
package gnms_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int FRAC_BITS = 12;
    localparam int DIV_BITS = 32;
    localparam int WEIGHT_BITS = FRAC_BITS + 1;
    localparam int PROD_BITS = 2 * WEIGHT_BITS;
    localparam int TERM_BITS = 16 + PROD_BITS;
    localparam int SUM_BITS = TERM_BITS + 2;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MINMAG = 2'd2,
        REG_NEAR   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [15:0] mag;
        logic        kill;
        logic        last;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic [143:0] win;
    } job_t;

    function automatic logic [15:0] win_at(input logic [143:0] w, input int idx);
        win_at = w[idx*16 +: 16];
    endfunction

    function automatic logic signed [1:0] near_off(input logic signed [16:0] n);
        logic signed [17:0] t;
        logic [3:0] q;
        logic signed [1:0] r;
        t = 18'(n) + 18'sd57344;
        q = 4'(t[17:14]);
        if (q <= 4'd2)
            r = -2'sd1;
        else if (q == 4'd3)
            r = 2'sd0;
        else
            r = 2'sd1;
        near_off = r;
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] to_frac(input logic signed [15:0] n);
        logic [16:0] f;
        f = n[15] ? 17'(n + 16'sd16384) : 17'(n);
        to_frac = WEIGHT_BITS'(f[16:0] >> (14 - FRAC_BITS));
    endfunction

endpackage
`default_nettype wire

// ----- src/gradient_nonmax_suppression_2d_core.sv -----
// Top level: line buffer memories, 3x3 window, decision sequencer and output register.
//
// Usage: pixels enter in raster order on in_valid/in_stall with grad_x, grad_y, magnitude.
// Each accepted beat at column >= 1 and row >= 1 yields one output beat on
// out_valid/out_stall carrying the result for the pixel one row and column back.
// Interior pixels go through a normalizing divider (two 30-step divisions) and a
// four-term bilinear multiply-accumulate. A steep gradient takes the nearest-neighbour
// path; border and below-threshold centers skip both; pixels with no output beat
// return to idle after the line buffer read.
// One item is in flight at a time.
// The line buffers sit in one synchronous memory read the cycle after acceptance.
// Reset clears counters and window, presets configuration; buffer contents are left as is
// and only reach border results. A stalled output holds its beat and blocks intake.
// Configuration writes are taken at any time but are meant for idle periods.
`default_nettype none
module gradient_nonmax_suppression_2d_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic signed [15:0] grad_x,
    input  wire logic signed [15:0] grad_y,
    input  wire logic [15:0] magnitude,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      maximum,
    output logic             frame_last
);
    import gnms_pkg::*;

    typedef enum logic [1:0] { T_IDLE, T_READ, T_WORK, T_OUT } tstate_t;

    logic [10:0] width_reg;
    logic [15:0] height_reg, minmag_reg;
    logic [14:0] near_reg;

    logic [63:0] line_mem [MAX_WIDTH];
    logic [63:0] line_rd;

    tstate_t state_reg;
    logic [COL_BITS-1:0] col_reg;
    logic [15:0] row_reg;
    logic [15:0] win_reg [9];
    logic [31:0] gdelay_reg;
    logic [15:0] in_mag_reg;
    logic [31:0] in_grad_reg;
    logic [COL_BITS-1:0] c_reg;
    logic [15:0] r_reg;
    logic [15:0] out_max_reg;
    logic out_last_reg;
    logic out_valid_reg;

    logic [10:0] w_eff;
    logic [15:0] h_eff;
    logic [COL_BITS-1:0] c_cur;
    logic [15:0] r_cur;
    logic accept;
    logic dec_start, dec_done;
    logic [15:0] dec_res;
    logic dec_last;
    job_t job;
    logic emit, interior, is_last;
    logic [15:0] win_nx [9];

    always_comb
    begin
        w_eff = (width_reg < 11'd3) ? 11'd3 : (width_reg > 11'(MAX_WIDTH) ? 11'(MAX_WIDTH)
                                                                          : width_reg);
        h_eff = (height_reg < 16'd3) ? 16'd3 : height_reg;
        c_cur = (11'(col_reg) >= w_eff) ? '0 : col_reg;
        r_cur = (row_reg >= h_eff) ? 16'd0 : row_reg;
        accept = in_valid && !in_stall;
        emit = (c_reg != '0) && (r_reg != 16'd0);
        interior = (c_reg >= COL_BITS'(2)) && (r_reg >= 16'd2);
        is_last = (11'(c_reg) == w_eff - 11'd1) && (r_reg == h_eff - 16'd1);
        for (int k = 0; k < 3; k++)
        begin
            win_nx[k*3] = win_reg[k*3+1];
            win_nx[k*3+1] = win_reg[k*3+2];
        end
        win_nx[2] = line_rd[15:0];
        win_nx[5] = line_rd[31:16];
        win_nx[8] = in_mag_reg;
        for (int i = 0; i < 9; i++)
            job.win[i*16 +: 16] = win_nx[i];
        job.mag = win_nx[4];
        job.kill = !interior;
        job.last = is_last;
        job.gx = gdelay_reg[15:0];
        job.gy = gdelay_reg[31:16];
        dec_start = (state_reg == T_READ) && emit;
    end

    assign in_stall = (state_reg != T_IDLE);

    always_ff @(posedge clk)
    begin
        if (accept)
            in_mag_reg <= magnitude;
        if (accept)
            in_grad_reg <= {grad_y, grad_x};
        if (accept)
            c_reg <= c_cur;
        if (accept)
            r_reg <= r_cur;
        line_rd <= line_mem[c_cur];
        if (state_reg == T_READ)
            line_mem[c_reg] <= {in_grad_reg, in_mag_reg, line_rd[31:16]};
    end

    gnms_decide u_dec (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (dec_start),
        .job           (job),
        .min_magnitude (minmag_reg),
        .near_threshold(near_reg),
        .done          (dec_done),
        .result        (dec_res),
        .result_last   (dec_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd1024;
            height_reg <= 16'd1024;
            minmag_reg <= 16'd1;
            near_reg <= 15'd16376;
            state_reg <= T_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            gdelay_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_reg <= cfg_data[10:0];
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_MINMAG: minmag_reg <= cfg_data;
                    REG_NEAR:   near_reg <= cfg_data[14:0];
                    default:    ;
                endcase
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= T_READ;
                        if (11'(c_cur) + 11'd1 >= w_eff)
                        begin
                            col_reg <= '0;
                            row_reg <= (r_cur + 16'd1 >= h_eff) ? 16'd0 : r_cur + 16'd1;
                        end
                        else
                        begin
                            col_reg <= c_cur + COL_BITS'(1);
                            row_reg <= r_cur;
                        end
                    end
                end
                T_READ:
                begin
                    for (int i = 0; i < 9; i++)
                        win_reg[i] <= win_nx[i];
                    gdelay_reg <= line_rd[63:32];
                    state_reg <= emit ? T_WORK : T_IDLE;
                end
                T_WORK:
                begin
                    if (dec_done)
                    begin
                        out_max_reg <= dec_res;
                        out_last_reg <= dec_last;
                        out_valid_reg <= 1'b1;
                        state_reg <= T_OUT;
                    end
                end
                T_OUT:
                begin
                    if (!out_stall)
                        state_reg <= T_IDLE;
                end
                default:
                    state_reg <= T_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign maximum = out_max_reg;
    assign frame_last = out_last_reg;

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != T_IDLE) |-> in_stall)
        else $error("intake open while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(maximum)))
        else $error("output beat dropped");
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == T_OUT))
        else $error("output valid outside output state");
endmodule
`default_nettype wire

// ----- src/gnms_divider.sv -----
// Restoring divider that normalizes one gradient component to Q1.14.
`default_nettype none
module gnms_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [15:0] num,
    input  wire logic [15:0]        den,
    output logic                    done,
    output logic signed [15:0]      quot
);
    import gnms_pkg::*;

    logic [29:0] rem_reg, rem_next;
    logic [29:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic [15:0] den_reg, den_next;
    logic        done_reg, done_next;
    logic signed [15:0] quot_reg, quot_next;
    logic [16:0] a;
    logic [30:0] trial;
    logic [29:0] qfin;

    always_comb
    begin
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        den_next = den_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        a = num[15] ? 17'(-18'(num)) : 17'(num);
        trial = '0;
        qfin = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'd30;
            neg_next = num[15];
            den_next = den;
            q_next = 30'({a, 14'd0});
            rem_next = '0;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, q_reg[29]};
            if (trial >= 31'(den_reg))
            begin
                rem_next = 30'(trial - 31'(den_reg));
                q_next = {q_reg[28:0], 1'b1};
            end
            else
            begin
                rem_next = trial[29:0];
                q_next = {q_reg[28:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                qfin = q_next;
                if (neg_reg)
                    quot_next = (qfin > 30'd32768) ? -16'sd32768 : 16'(-31'(qfin));
                else
                    quot_next = (qfin > 30'd32767) ? 16'sd32767 : 16'(qfin);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        neg_reg <= neg_next;
        den_reg <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

// ----- src/gnms_decide.sv -----
// Sequencer that decides whether the window center is a maximum along its gradient.
`default_nettype none
module gnms_decide (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire gnms_pkg::job_t       job,
    input  wire logic [15:0]          min_magnitude,
    input  wire logic [14:0]          near_threshold,
    output logic                      done,
    output logic [15:0]               result,
    output logic                      result_last
);
    import gnms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIVX, S_DIVY, S_SETUP, S_FWD, S_BWD, S_DONE
    } state_t;

    state_t state_reg;
    job_t   job_reg;
    logic signed [15:0] nx_reg, ny_reg;
    logic [15:0] res_reg;
    logic done_reg;
    logic [1:0] term_reg;
    logic [SUM_BITS-1:0] acc_reg;
    logic [WEIGHT_BITS-1:0] dx_reg, dy_reg;
    logic [PROD_BITS-1:0] cw_reg [4];
    logic [TERM_BITS-1:0] prod_reg;
    logic prod_ok_reg;

    logic div_start;
    logic div_done;
    logic signed [15:0] div_q;
    logic signed [15:0] div_num;

    assign div_num = (state_reg == S_DIVY || (state_reg == S_DIVX && div_done)) ? job_reg.gy
                                                                              : job_reg.gx;

    gnms_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (job_reg.mag),
        .done (div_done),
        .quot (div_q)
    );

    logic started_reg;
    assign div_start = (state_reg == S_DIVX && !started_reg)
                    || (state_reg == S_DIVX && div_done);

    logic [15:0] thr;
    logic [15:0] ax, ay;
    logic use_near;
    logic signed [1:0] ofx, ofy, obx, oby;
    logic [15:0] sn_f, sn_b;
    logic [WEIGHT_BITS-1:0] one;
    logic [1:0] ux, uy;
    logic [15:0] pix;
    logic [PROD_BITS-1:0] wsel;
    logic [SUM_BITS-1:0] refv;
    logic [1:0] pr, pc;

    always_comb
    begin
        thr = (near_threshold > 15'd16383) ? 16'd16383 : 16'(near_threshold);
        ax = nx_reg[15] ? 16'(-17'(nx_reg)) : 16'(nx_reg);
        ay = ny_reg[15] ? 16'(-17'(ny_reg)) : 16'(ny_reg);
        use_near = (ax > thr) || (ay > thr);
        ofx = near_off(17'(nx_reg));
        ofy = near_off(17'(ny_reg));
        obx = near_off(-17'(nx_reg));
        oby = near_off(-17'(ny_reg));
        sn_f = win_at(job_reg.win, int'(3*(1+int'(ofy)) + 1 + int'(ofx)));
        sn_b = win_at(job_reg.win, int'(3*(1+int'(oby)) + 1 + int'(obx)));
        one = WEIGHT_BITS'(1) << FRAC_BITS;
        refv = SUM_BITS'(job_reg.mag) << (2*FRAC_BITS);
        if (state_reg == S_FWD)
        begin
            ux = nx_reg[15] ? 2'd0 : 2'd1;
            uy = ny_reg[15] ? 2'd0 : 2'd1;
            wsel = cw_reg[term_reg];
        end
        else
        begin
            ux = (nx_reg > 0) ? 2'd0 : 2'd1;
            uy = (ny_reg > 0) ? 2'd0 : 2'd1;
            wsel = cw_reg[2'd3 - term_reg];
        end
        pr = uy + {1'b0, term_reg[1]};
        pc = ux + {1'b0, term_reg[0]};
        pix = win_at(job_reg.win, int'(pr) * 3 + int'(pc));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            started_reg <= 1'b0;
            prod_ok_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        job_reg <= job;
                        started_reg <= 1'b0;
                        if (job.kill || job.mag == 16'd0 || job.mag < min_magnitude)
                        begin
                            res_reg <= 16'd0;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_DIVX;
                    end
                end
                S_DIVX:
                begin
                    started_reg <= 1'b1;
                    if (div_done)
                    begin
                        nx_reg <= div_q;
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (div_done)
                    begin
                        ny_reg <= div_q;
                        state_reg <= S_SETUP;
                        term_reg <= 2'd0;
                    end
                end
                S_SETUP:
                begin
                    dx_reg <= to_frac(nx_reg);
                    dy_reg <= to_frac(ny_reg);
                    if (use_near)
                    begin
                        res_reg <= (job_reg.mag <= sn_f || job_reg.mag < sn_b) ? 16'd0
                                                                               : job_reg.mag;
                        state_reg <= S_DONE;
                    end
                    else if (term_reg == 2'd0)
                        term_reg <= 2'd1;
                    else
                    begin
                        cw_reg[0] <= PROD_BITS'((one - dx_reg) * (one - dy_reg));
                        cw_reg[1] <= PROD_BITS'(dx_reg * (one - dy_reg));
                        cw_reg[2] <= PROD_BITS'((one - dx_reg) * dy_reg);
                        cw_reg[3] <= PROD_BITS'(dx_reg * dy_reg);
                        term_reg <= 2'd0;
                        acc_reg <= '0;
                        prod_ok_reg <= 1'b0;
                        state_reg <= S_FWD;
                    end
                end
                S_FWD, S_BWD:
                begin
                    if (term_reg == 2'd0 && prod_ok_reg)
                    begin
                        term_reg <= 2'd0;
                        prod_ok_reg <= 1'b0;
                        acc_reg <= '0;
                        if (state_reg == S_FWD)
                        begin
                            if (refv <= acc_reg + SUM_BITS'(prod_reg))
                            begin
                                res_reg <= 16'd0;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_BWD;
                        end
                        else
                        begin
                            res_reg <= (refv < acc_reg + SUM_BITS'(prod_reg)) ? 16'd0
                                                                              : job_reg.mag;
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        prod_reg <= TERM_BITS'(pix * wsel);
                        prod_ok_reg <= 1'b1;
                        if (prod_ok_reg)
                            acc_reg <= acc_reg + SUM_BITS'(prod_reg);
                        term_reg <= term_reg + 2'd1;
                    end
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign result = res_reg;
    assign result_last = job_reg.last;
endmodule
`default_nettype wire

// ----- tb/sv/gnms_checker.sv -----
// Checker for the non-maximum suppression core: predicts each result and compares the output.
`timescale 1ns / 100ps
`default_nettype none
module gnms_checker
    import gnms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic signed [15:0] grad_x,
    input  wire logic signed [15:0] grad_y,
    input  wire logic [15:0] magnitude,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [15:0] maximum,
    input  wire logic        frame_last,
    output int               failures,
    output int               pending
);

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [15:0] min_mag_reg;
    logic [14:0] near_reg;

    logic [15:0] mag_lines[2*MAX_WIDTH];
    logic [31:0] grad_line[MAX_WIDTH];
    logic [15:0] window[9];
    logic [31:0] grad_hold;
    int unsigned col_pos;
    int unsigned row_pos;

    logic [15:0] want_max[$];
    logic        want_last[$];

    assign pending = want_max.size();

    initial
    begin
        failures = 0;
        foreach (mag_lines[i]) mag_lines[i] = '0;
        foreach (grad_line[i]) grad_line[i] = '0;
    end

    function automatic int scale_component(input int g, input int unsigned m);
        int unsigned a;
        int unsigned q;
        a = (g < 0) ? -g : g;
        q = (a << 14) / m;
        if (g < 0)
            return (q > 32768) ? -32768 : -int'(q);
        return (q > 32767) ? 32767 : int'(q);
    endfunction

    function automatic int step_offset(input int n);
        int o;
        o = ((n + 57344) >>> 14) - 3;
        if (o < -1) o = -1;
        if (o > 1) o = 1;
        return o;
    endfunction

    function automatic longint unsigned frac_of(input int n);
        int f;
        f = (n < 0) ? n + 16384 : n;
        return longint'(f >> (14 - FRAC_BITS));
    endfunction

    function automatic longint unsigned pix(input int r, input int c);
        return longint'(window[(r * 3 + c) % 9]);
    endfunction

    function automatic logic [15:0] suppress(input int gx, input int gy);
        int unsigned mag;
        int nx, ny, thr, ax, ay, ux, uy;
        longint unsigned one, dx, dy, c00, c10, c01, c11, ref_val, acc;
        mag = window[4];
        if (mag < min_mag_reg || mag == 0)
            return 0;
        nx = scale_component(gx, mag);
        ny = scale_component(gy, mag);
        thr = (near_reg > 16383) ? 16383 : near_reg;
        ax = (nx < 0) ? -nx : nx;
        ay = (ny < 0) ? -ny : ny;
        if (ax > thr || ay > thr)
        begin
            if (mag <= pix(1 + step_offset(ny), 1 + step_offset(nx)))
                return 0;
            if (mag < pix(1 + step_offset(-ny), 1 + step_offset(-nx)))
                return 0;
            return mag[15:0];
        end
        one = 64'd1 << FRAC_BITS;
        dx = frac_of(nx);
        dy = frac_of(ny);
        c00 = (one - dx) * (one - dy);
        c10 = dx * (one - dy);
        c01 = (one - dx) * dy;
        c11 = dx * dy;
        ref_val = longint'(mag) << (2 * FRAC_BITS);
        ux = (nx < 0) ? 0 : 1;
        uy = (ny < 0) ? 0 : 1;
        acc = pix(uy, ux) * c00 + pix(uy, ux + 1) * c10
            + pix(uy + 1, ux) * c01 + pix(uy + 1, ux + 1) * c11;
        if (ref_val <= acc)
            return 0;
        ux = (nx > 0) ? 0 : 1;
        uy = (ny > 0) ? 0 : 1;
        acc = pix(uy, ux) * c11 + pix(uy, ux + 1) * c01
            + pix(uy + 1, ux) * c10 + pix(uy + 1, ux + 1) * c00;
        if (ref_val < acc)
            return 0;
        return mag[15:0];
    endfunction

    task automatic predict_pixel(input logic signed [15:0] gx, input logic signed [15:0] gy,
                                 input logic [15:0] m);
        int unsigned w, h, c, r;
        logic [31:0] center;
        logic [15:0] top_px, mid_px;
        w = width_reg;
        h = height_reg;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 3) h = 3;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        top_px = mag_lines[c];
        mid_px = mag_lines[MAX_WIDTH + c];
        for (int k = 0; k < 3; k++)
        begin
            window[k * 3] = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2] = top_px;
        window[5] = mid_px;
        window[8] = m;
        mag_lines[c] = mid_px;
        mag_lines[MAX_WIDTH + c] = m;
        center = grad_hold;
        grad_hold = grad_line[c];
        grad_line[c] = {gy, gx};
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
        if (c < 1 || r < 1)
            return;
        if (c >= 2 && r >= 2)
            want_max.push_back(suppress(int'($signed(center[15:0])),
                                        int'($signed(center[31:16]))));
        else
            want_max.push_back(16'd0);
        want_last.push_back(c == w - 1 && r == h - 1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd1024;
            height_reg <= 16'd1024;
            min_mag_reg <= 16'd1;
            near_reg <= 15'd16376;
            foreach (window[i]) window[i] = '0;
            grad_hold = '0;
            col_pos = 0;
            row_pos = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (reg_index_t'(cfg_index))
                    REG_WIDTH:  width_reg <= cfg_data[10:0];
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_MINMAG: min_mag_reg <= cfg_data;
                    REG_NEAR:   near_reg <= cfg_data[14:0];
                    default:    ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (want_max.size() == 0)
                begin
                    $error("unexpected beat: maximum %0d frame_last %0d", maximum, frame_last);
                    failures++;
                end
                else
                begin
                    if (maximum !== want_max[0])
                    begin
                        $error("maximum mismatch: expected %0d, actual %0d",
                               want_max[0], maximum);
                        failures++;
                    end
                    if (frame_last !== want_last[0])
                    begin
                        $error("frame_last mismatch: expected %0d, actual %0d",
                               want_last[0], frame_last);
                        failures++;
                    end
                    void'(want_max.pop_front());
                    void'(want_last.pop_front());
                end
            end
            if (in_valid && !in_stall)
                predict_pixel(grad_x, grad_y, magnitude);
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Top of the testbench: clock, reset, pixel stimulus, output stall and the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import gnms_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 100;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic [15:0] magnitude;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] maximum;
    logic        frame_last;
    int          failures;
    int          pending;
    int          cycles;
    int          burst_left;
    int          pixels_sent;

    gradient_nonmax_suppression_2d_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .magnitude  (magnitude),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .maximum    (maximum),
        .frame_last (frame_last)
    );

    gnms_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .magnitude  (magnitude),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .maximum    (maximum),
        .frame_last (frame_last),
        .failures   (failures),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int mode;
            int span;
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    task automatic write_reg(input reg_index_t idx, input int unsigned value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_pixel(input logic signed [15:0] gx, input logic signed [15:0] gy,
                              input logic [15:0] m);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        grad_x <= gx;
        grad_y <= gy;
        magnitude <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    function automatic logic [15:0] pick_magnitude(input int c, input int r, input int ridge);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            return 16'($urandom);
        if (sel < 4)
            return 16'd0;
        if (c == ridge || c + r == ridge)
            return 16'($urandom_range(1500, 4000));
        return 16'($urandom_range(0, 2000));
    endfunction

    function automatic logic signed [15:0] pick_gradient(input logic [15:0] m);
        int lim;
        lim = (m > 32767) ? 32767 : m;
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * lim)) - lim);
    endfunction

    task automatic run_rows(input int w, input int rows);
        int ridge;
        logic [15:0] m;
        ridge = $urandom_range(0, w);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < w; c++)
            begin
                m = pick_magnitude(c, r, ridge);
                send_pixel(pick_gradient(m), pick_gradient(m), m);
            end
    endtask

    task automatic setup_frame(input int w, input int h, input int mm, input int nt);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MINMAG, mm);
        write_reg(REG_NEAR, nt);
    endtask

    initial
    begin
        logic [15:0] dir_mag[25];
        logic signed [15:0] dir_gx[25];
        logic signed [15:0] dir_gy[25];
        int w, h, mm, nt, phase;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        grad_x = '0;
        grad_y = '0;
        magnitude = '0;
        cycles = 0;
        burst_left = 10;
        pixels_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_mag = '{16'd100, 16'd100, 16'd100, 16'd100, 16'd100,
                    16'd100, 16'd500, 16'd500, 16'd65535, 16'd100,
                    16'd100, 16'd500, 16'd900, 16'd0, 16'd100,
                    16'd100, 16'd1, 16'd500, 16'd500, 16'd100,
                    16'd100, 16'd100, 16'd100, 16'd100, 16'd65535};
        dir_gx = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                   16'sd0, 16'sd500, -16'sd500, 16'sd32767, 16'sd0,
                   16'sd0, 16'sd0, 16'sd300, 16'sd5, 16'sd0,
                   16'sd0, -16'sd32768, 16'sd250, -16'sd350, 16'sd0,
                   16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768};
        dir_gy = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                   16'sd0, 16'sd0, 16'sd500, 16'sd0, 16'sd0,
                   16'sd0, 16'sd500, -16'sd300, 16'sd5, 16'sd0,
                   16'sd0, 16'sd32767, -16'sd433, 16'sd350, 16'sd0,
                   16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767};
        setup_frame(5, 5, 1, 16376);
        for (int i = 0; i < 25; i++)
            send_pixel(dir_gx[i], dir_gy[i], dir_mag[i]);

        phase = 0;
        while (pixels_sent < 1060)
        begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            mm = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(0, 3000);
            nt = $urandom_range(0, 16384);
            case (phase)
                0: mm = 0;
                1: mm = 65535;
                2: nt = 0;
                3: nt = 16384;
                4: w = 3;
                5: nt = 16383;
                default: ;
            endcase
            setup_frame(w, h, mm, nt);
            run_rows(w, h);
            phase++;
        end

        setup_frame(3, 65535, 200, 8000);
        run_rows(3, 5);

        drain();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
src/gnms_pkg.sv
src/gnms_divider.sv
src/gnms_decide.sv
src/gradient_nonmax_suppression_2d_core.sv
tb/sv/gnms_checker.sv
tb/sv/tb_top.sv
